### sv/vog_pkg.sv
// Package for the voxel occupancy grid: map geometry, widths, command codes,
// status codes and the queued command type. No dependencies.
`timescale 1ns / 1ps

package vog_pkg;

    // Map geometry
    localparam int MAP_CELLS  = 16;
    localparam int CELL_SIZE  = 8;
    localparam int LEVELS     = 4;
    localparam int AXIS       = MAP_CELLS * CELL_SIZE;
    localparam int HALF_SHIFT = (MAP_CELLS / 2) * CELL_SIZE;
    localparam int DEPTH      = AXIS * AXIS * LEVELS;

    // Widths
    localparam int AXIS_W  = (AXIS > 1) ? $clog2(AXIS) : 1;
    localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COORD_W = 18;
    localparam int ID_W    = 32;
    localparam int QDEPTH  = 2;
    localparam int Q_AW    = 1;

    // Action codes
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_PLACE  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_OCC   = 2'd2;

    // Classified command kinds
    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_PLACE  = 2'd1,
        OP_REJECT = 2'd2
    } t_op;

    // Command handed from the front to the back
    typedef struct packed {
        t_op               op;
        logic [AXIS_W-1:0] gx;
        logic [AXIS_W-1:0] gy;
        logic [LVL_W-1:0]  gz;
        logic [AXIS_W-1:0] ex;
        logic [AXIS_W-1:0] ey;
        logic [LVL_W-1:0]  ez;
        logic [ID_W-1:0]   id;
    } t_cmd;

    // Flat store address of voxel (x, y, z)
    function automatic logic [ADDR_W-1:0] f_addr(
        input logic [AXIS_W-1:0] x,
        input logic [AXIS_W-1:0] y,
        input logic [LVL_W-1:0]  z
    );
        logic [ADDR_W-1:0] plane;
        logic [ADDR_W-1:0] row;
        plane = ADDR_W'(AXIS * AXIS);
        row   = ADDR_W'(AXIS);
        return ADDR_W'(ADDR_W'(z) * plane) + ADDR_W'(ADDR_W'(y) * row) + ADDR_W'(x);
    endfunction

endpackage

### sv/vog_front.sv
// Front end of the voxel grid: accepts items, shifts positions into map
// coordinates, checks range and size, and pushes a command. Uses vog_pkg.
`timescale 1ns / 1ps

module vog_front (
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_action,
    input  logic signed [15:0]       i_pos_x,
    input  logic signed [15:0]       i_pos_y,
    input  logic signed [15:0]       i_pos_z,
    input  logic signed [8:0]        i_size_x,
    input  logic signed [8:0]        i_size_y,
    input  logic signed [8:0]        i_size_z,
    input  logic [vog_pkg::ID_W-1:0] i_entity_id,
    input  logic                     i_q_full,
    input  logic                     i_init_done,
    output logic                     o_push,
    output vog_pkg::t_cmd            o_cmd
);
    import vog_pkg::*;

    localparam logic signed [COORD_W-1:0] C_AXIS  = COORD_W'(AXIS);
    localparam logic signed [COORD_W-1:0] C_LVL   = COORD_W'(LEVELS);
    localparam logic signed [COORD_W-1:0] C_SHIFT = COORD_W'(HALF_SHIFT);
    localparam logic signed [COORD_W-1:0] C_ONE   = COORD_W'(1);

    logic signed [COORD_W-1:0] w_gx, w_gy, w_gz;
    logic signed [COORD_W-1:0] w_ex, w_ey, w_ez;
    logic                      w_org_in, w_end_in, w_size_ok;

    function automatic logic f_in_map(
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y,
        input logic signed [COORD_W-1:0] z
    );
        return (x >= 0) && (x < C_AXIS) && (y >= 0) && (y < C_AXIS)
            && (z >= 0) && (z < C_LVL);
    endfunction

    // Shift x and y to map coordinates; level stays as given
    assign w_gx = COORD_W'(i_pos_x) + C_SHIFT;
    assign w_gy = COORD_W'(i_pos_y) + C_SHIFT;
    assign w_gz = COORD_W'(i_pos_z);

    // Inclusive far corner of the box
    assign w_ex = w_gx + COORD_W'(i_size_x) - C_ONE;
    assign w_ey = w_gy + COORD_W'(i_size_y) - C_ONE;
    assign w_ez = w_gz + COORD_W'(i_size_z) - C_ONE;

    assign w_org_in  = f_in_map(w_gx, w_gy, w_gz);
    assign w_end_in  = f_in_map(w_ex, w_ey, w_ez);
    assign w_size_ok = (i_size_x > 9'sd0) && (i_size_y > 9'sd0) && (i_size_z > 9'sd0);

    // Accept while the queue has room and the store is cleared
    assign o_in_ready = !i_q_full && i_init_done;
    assign o_push     = i_in_valid && o_in_ready;

    // Classify the item
    always_comb begin
        o_cmd.gx = w_gx[AXIS_W-1:0];
        o_cmd.gy = w_gy[AXIS_W-1:0];
        o_cmd.gz = w_gz[LVL_W-1:0];
        o_cmd.ex = w_ex[AXIS_W-1:0];
        o_cmd.ey = w_ey[AXIS_W-1:0];
        o_cmd.ez = w_ez[LVL_W-1:0];
        o_cmd.id = i_entity_id;
        if (i_action == ACT_LOOKUP) begin
            o_cmd.op = w_org_in ? OP_LOOKUP : OP_REJECT;
        end else begin
            o_cmd.op = (w_size_ok && w_org_in && w_end_in) ? OP_PLACE : OP_REJECT;
        end
    end

endmodule

### sv/vog_queue.sv
// Two-entry command queue between the front and the back of the voxel grid.
// Uses vog_pkg.
`timescale 1ns / 1ps

module vog_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vog_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output vog_pkg::t_cmd o_cmd
);
    import vog_pkg::*;

    localparam logic [Q_AW:0] C_FULL = (Q_AW + 1)'(QDEPTH);

    t_cmd            r_mem [QDEPTH];
    logic [Q_AW-1:0] r_wr, n_wr;
    logic [Q_AW-1:0] r_rd, n_rd;
    logic [Q_AW:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == C_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    // Advance pointers and count
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_full |-> !i_push)
        else $error("queue pushed while full");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !o_valid |-> !i_pop)
        else $error("queue popped while empty");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= C_FULL)
        else $error("queue count beyond depth");

endmodule

### sv/vog_back.sv
// Back end of the voxel grid: clears the store after reset, runs lookups,
// walks placement boxes to check and write, holds the result. Uses vog_pkg.
`timescale 1ns / 1ps

module vog_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  vog_pkg::t_cmd            i_q_cmd,
    output logic                     o_q_pop,
    output logic                     o_init_done,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [vog_pkg::ID_W-1:0] o_found_id,
    output logic [1:0]               o_status
);
    import vog_pkg::*;

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_LRD  = 7'b0000100,
        S_LEV  = 7'b0001000,
        S_CRD  = 7'b0010000,
        S_CEV  = 7'b0100000,
        S_WR   = 7'b1000000
    } t_state;

    localparam logic [ADDR_W-1:0] C_LAST = ADDR_W'(DEPTH - 1);

    logic [ID_W-1:0]   r_store [DEPTH];
    logic [ID_W-1:0]   r_rdata;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [AXIS_W-1:0] r_x, n_x;
    logic [AXIS_W-1:0] r_y, n_y;
    logic [LVL_W-1:0]  r_z, n_z;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic              r_out_valid, n_out_valid;
    logic [ID_W-1:0]   r_found, n_found;
    logic [1:0]        r_status, n_status;

    logic [ADDR_W-1:0] w_addr;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [ID_W-1:0]   w_wdata;
    logic              w_last;
    logic [AXIS_W-1:0] w_nx, w_ny;
    logic [LVL_W-1:0]  w_nz;

    assign w_addr      = f_addr(r_x, r_y, r_z);
    assign w_last      = (r_x == r_cmd.ex) && (r_y == r_cmd.ey) && (r_z == r_cmd.ez);
    assign o_init_done = (r_state != S_CLR);
    assign o_out_valid = r_out_valid;
    assign o_found_id  = r_found;
    assign o_status    = r_status;

    // Step the box walk: x fastest, then y, then level
    always_comb begin
        w_nx = r_x + 1'b1;
        w_ny = r_y;
        w_nz = r_z;
        if (r_x == r_cmd.ex) begin
            w_nx = r_cmd.gx;
            w_ny = r_y + 1'b1;
            if (r_y == r_cmd.ey) begin
                w_ny = r_cmd.gy;
                w_nz = r_z + 1'b1;
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_clr       = r_clr;
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_status    = r_status;
        o_q_pop     = 1'b0;
        w_we        = 1'b0;
        w_waddr     = w_addr;
        w_wdata     = r_cmd.id;

        // Drop the result once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == C_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid && !r_out_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_x     = i_q_cmd.gx;
                    n_y     = i_q_cmd.gy;
                    n_z     = i_q_cmd.gz;
                    case (i_q_cmd.op)
                        OP_LOOKUP: n_state = S_LRD;
                        OP_PLACE:  n_state = S_CRD;
                        default: begin
                            n_out_valid = 1'b1;
                            n_found     = '0;
                            n_status    = ST_RANGE;
                        end
                    endcase
                end
            end
            S_LRD: begin
                n_state = S_LEV;
            end
            S_LEV: begin
                n_out_valid = 1'b1;
                n_found     = r_rdata;
                n_status    = ST_OK;
                n_state     = S_IDLE;
            end
            S_CRD: begin
                n_state = S_CEV;
            end
            S_CEV: begin
                if (r_rdata != '0) begin
                    n_out_valid = 1'b1;
                    n_found     = '0;
                    n_status    = ST_OCC;
                    n_state     = S_IDLE;
                end else if (w_last) begin
                    n_x     = r_cmd.gx;
                    n_y     = r_cmd.gy;
                    n_z     = r_cmd.gz;
                    n_state = S_WR;
                end else begin
                    n_x     = w_nx;
                    n_y     = w_ny;
                    n_z     = w_nz;
                    n_state = S_CRD;
                end
            end
            S_WR: begin
                w_we = 1'b1;
                if (w_last) begin
                    n_out_valid = 1'b1;
                    n_found     = '0;
                    n_status    = ST_OK;
                    n_state     = S_IDLE;
                end else begin
                    n_x = w_nx;
                    n_y = w_ny;
                    n_z = w_nz;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_x      <= n_x;
        r_y      <= n_y;
        r_z      <= n_z;
        r_found  <= n_found;
        r_status <= n_status;
    end

    // Voxel store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_waddr] <= w_wdata;
        end
        r_rdata <= r_store[w_addr];
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !r_out_valid)
        else $error("result raised during store clear");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE) && !r_out_valid)
        else $error("command popped while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (r_cmd.op == OP_PLACE))
        else $error("write walk without a placement");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CEV) && (r_rdata != '0) |=> r_out_valid && (r_status == ST_OCC))
        else $error("occupied voxel not reported");

endmodule

### sv/voxel_occupancy_grid_core.sv
// Voxel occupancy grid top level: front classifier, command queue, back end.
// Lookup: the queued command is read, evaluated and the result registered; a
// new command is taken only when the back is idle with no result pending.
// Placement: a check walk reads each voxel, then a write walk writes the id;
// rejects are answered from idle. Reset (synchronous, active low) clears all
// 65536 store words, one word a cycle; no item is accepted meanwhile.
`timescale 1ns / 1ps

module voxel_occupancy_grid_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_action,
    input  logic signed [15:0]       i_pos_x,
    input  logic signed [15:0]       i_pos_y,
    input  logic signed [15:0]       i_pos_z,
    input  logic signed [8:0]        i_size_x,
    input  logic signed [8:0]        i_size_y,
    input  logic signed [8:0]        i_size_z,
    input  logic [vog_pkg::ID_W-1:0] i_entity_id,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [vog_pkg::ID_W-1:0] o_found_id,
    output logic [1:0]               o_status
);
    import vog_pkg::*;

    t_cmd w_push_cmd;
    t_cmd w_head_cmd;
    logic w_push, w_full, w_pop, w_head_valid, w_init_done;

    vog_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_size_x    (i_size_x),
        .i_size_y    (i_size_y),
        .i_size_z    (i_size_z),
        .i_entity_id (i_entity_id),
        .i_q_full    (w_full),
        .i_init_done (w_init_done),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    vog_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_cmd   (w_head_cmd)
    );

    vog_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_head_valid),
        .i_q_cmd     (w_head_cmd),
        .o_q_pop     (w_pop),
        .o_init_done (w_init_done),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_found_id  (o_found_id),
        .o_status    (o_status)
    );

endmodule
